// ===== rtl/nbm_pkg.sv =====
// ----------------------------------------------------------------------------
// nbm_pkg
// Shared types and codes for the bitset NFA matcher: request and edge kind
// codes, register indexes, the edge table entry and the channel items.
// ----------------------------------------------------------------------------
`default_nettype none

package nbm_pkg;

    // Fixed field widths.
    localparam int STATE_W = 64;
    localparam int SID_W   = 6;
    localparam int CHAR_W  = 8;
    localparam int SLOT_W  = 7;
    // Wide enough to hold any table depth and any slot or count compare.
    localparam int WIDE_W  = 11;

    // Request codes.
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_BEGIN   = 2'd1;
    localparam logic [1:0] REQ_CONSUME = 2'd2;

    // Edge kinds.
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_LITERAL  = 2'd1;
    localparam logic [1:0] KIND_WILDCARD = 2'd2;
    localparam logic [1:0] KIND_EPSILON  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EDGES_IN_USE = 2'd0;
    localparam logic [1:0] CFG_START_INDEX  = 2'd1;
    localparam logic [1:0] CFG_ACCEPT_INDEX = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_CLOSE,
        ST_DONE
    } nbm_state_t;

    // One edge table entry.
    typedef struct packed {
        logic [SID_W-1:0]  src;
        logic [SID_W-1:0]  dst;
        logic [1:0]        kind;
        logic [CHAR_W-1:0] code;
    } nbm_edge_t;

    // Controls for the shared edge unit.
    typedef struct packed {
        logic              advance;
        logic [CHAR_W-1:0] ch;
    } nbm_unit_ctrl_t;

    // Request item.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [SLOT_W-1:0] edge_slot;
        logic [SID_W-1:0]  edge_source;
        logic [SID_W-1:0]  edge_target;
        logic [1:0]        edge_kind;
        logic [CHAR_W-1:0] edge_byte;
        logic [CHAR_W-1:0] text_byte;
    } nbm_in_t;

    // Result item.
    typedef struct packed {
        logic               matched;
        logic [STATE_W-1:0] active_set;
    } nbm_out_t;

endpackage

`default_nettype wire

// ===== rtl/nbm_edge_ram.sv =====
// ----------------------------------------------------------------------------
// nbm_edge_ram
// Edge table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module nbm_edge_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire nbm_pkg::nbm_edge_t wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output nbm_pkg::nbm_edge_t     rd_data
);
    import nbm_pkg::*;

    nbm_edge_t mem [DEPTH];
    nbm_edge_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/nbm_edge_unit.sv =====
// ----------------------------------------------------------------------------
// nbm_edge_unit
// Shared edge evaluator: decides whether one edge fires from a source set and
// ORs its target state into an accumulated set.
// ----------------------------------------------------------------------------
`default_nettype none

module nbm_edge_unit #(
    parameter int NS = 64
) (
    input  wire nbm_pkg::nbm_edge_t      edge_in,
    input  wire nbm_pkg::nbm_unit_ctrl_t ctrl,
    input  wire logic [NS-1:0]           src_set,
    input  wire logic [NS-1:0]           acc_set,
    output logic [NS-1:0]                new_set,
    output logic                         changed
);
    import nbm_pkg::*;

    logic [STATE_W-1:0] src_ext;
    logic [STATE_W-1:0] dst_dec;
    logic               fires;

    // Kind match: literal and wildcard edges in the advance pass, epsilon
    // edges in the closure pass.
    always_comb
    begin
        fires = 1'b0;
        case (edge_in.kind)
            KIND_LITERAL:  fires = ctrl.advance && (edge_in.code == ctrl.ch);
            KIND_WILDCARD: fires = ctrl.advance;
            KIND_EPSILON:  fires = !ctrl.advance;
            default:       fires = 1'b0;
        endcase
    end

    // States at or above NS read as inactive and decode to no bit.
    always_comb
    begin
        src_ext              = '0;
        src_ext[NS-1:0]      = src_set;
        dst_dec              = '0;
        dst_dec[edge_in.dst] = 1'b1;
        new_set = acc_set;
        if (fires && src_ext[edge_in.src])
        begin
            new_set = acc_set | dst_dec[NS-1:0];
        end
        changed = (new_set != acc_set);
    end

endmodule

`default_nettype wire

// ===== rtl/nfa_bitset_matcher.sv =====
// ----------------------------------------------------------------------------
// nfa_bitset_matcher
// Bitset simulation of a Thompson NFA over a loaded edge table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_item) takes write, begin and consume
//   items; rsp channel (rsp_valid/rsp_stall/rsp_item) returns one item per
//   request with the active state set and the accept flag. The cfg channel
//   writes edges_in_use, start_index and accept_index; it is always ready.
//   The user must see that it is written only while the block is idle; the
//   block itself does not enforce this. A write item, or an unused request
//   code, goes straight to the done state, which loads its result into the
//   output register. Every walk of the edge table covers the first
//   min(edges_in_use, MAX_EDGES) slots through the single read port of the
//   table and the shared edge unit. A consume item takes one advance walk,
//   then closure walks until one changes nothing; a begin item takes closure
//   walks only. No new request is accepted until the result of the current
//   one is loaded into the output register.
// Reset clears the active set, the registers and the handshake state; the
// edge table holds no defined contents until written. A stalled result stays
// in the output register; the next request may be accepted meanwhile but
// finishes only once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_bitset_matcher #(
    parameter int MAX_EDGES  = 128,
    parameter int NUM_STATES = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire nbm_pkg::nbm_in_t req_item,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output nbm_pkg::nbm_out_t     rsp_item,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [7:0]       cfg_data
);
    import nbm_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int NS = NUM_STATES;

    // Configuration registers.
    logic [7:0]       edges_in_use_reg;
    logic [SID_W-1:0] start_index_reg;
    logic [SID_W-1:0] accept_index_reg;

    // Sequencer and datapath registers.
    nbm_state_t       state_reg, state_next;
    logic [CW-1:0]    idx_reg;
    logic             data_valid_reg;
    logic             changed_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [NS-1:0]    cur_reg;
    logic [NS-1:0]    work_reg;
    logic             rsp_valid_reg;
    nbm_out_t         rsp_item_reg;

    // Combinational signals.
    logic               req_accept;
    logic               rsp_free;
    logic               walking;
    logic               rd_en;
    logic               pass_end;
    logic [WIDE_W-1:0]  count_wide;
    logic [WIDE_W-1:0]  live_wide;
    logic [CW-1:0]      n_live;
    logic [WIDE_W-1:0]  slot_wide;
    logic               wr_en;
    nbm_edge_t          wr_edge;
    nbm_edge_t          rd_edge;
    nbm_unit_ctrl_t     unit_ctrl;
    logic [NS-1:0]      unit_src;
    logic [NS-1:0]      unit_set;
    logic               unit_changed;
    logic [STATE_W-1:0] start_dec;
    logic [STATE_W-1:0] work_ext;
    logic [STATE_W-1:0] cur_ext;

    // Handshake.
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_item   = rsp_item_reg;
    assign cfg_ready  = 1'b1;

    // Number of live edges, saturated to the table depth.
    always_comb
    begin
        count_wide = WIDE_W'(edges_in_use_reg);
        live_wide  = (count_wide > WIDE_W'(MAX_EDGES)) ? WIDE_W'(MAX_EDGES) : count_wide;
        n_live     = live_wide[CW-1:0];
    end

    // Edge table write from a write item; slots beyond the table are dropped.
    always_comb
    begin
        slot_wide    = WIDE_W'(req_item.edge_slot);
        wr_en        = req_accept && (req_item.req_type == REQ_WRITE) &&
                       (slot_wide < WIDE_W'(MAX_EDGES));
        wr_edge.src  = req_item.edge_source;
        wr_edge.dst  = req_item.edge_target;
        wr_edge.kind = req_item.edge_kind;
        wr_edge.code = req_item.edge_byte;
    end

    nbm_edge_ram #(
        .DEPTH (MAX_EDGES),
        .AW    (AW)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_wide[AW-1:0]),
        .wr_data (wr_edge),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_edge)
    );

    nbm_edge_unit #(
        .NS (NS)
    ) u_edge_unit (
        .edge_in (rd_edge),
        .ctrl    (unit_ctrl),
        .src_set (unit_src),
        .acc_set (work_reg),
        .new_set (unit_set),
        .changed (unit_changed)
    );

    // Set decode and widening to the output width.
    always_comb
    begin
        start_dec                  = '0;
        start_dec[start_index_reg] = 1'b1;
        work_ext                   = '0;
        work_ext[NS-1:0]           = work_reg;
        cur_ext                    = '0;
        cur_ext[NS-1:0]            = cur_reg;
    end

    // Sequencer outputs.
    always_comb
    begin
        walking           = (state_reg == ST_ADVANCE) || (state_reg == ST_CLOSE);
        rd_en             = walking && (idx_reg < n_live);
        pass_end          = walking && (idx_reg == n_live) && !data_valid_reg;
        unit_ctrl.advance = (state_reg == ST_ADVANCE);
        unit_ctrl.ch      = char_reg;
        unit_src          = (state_reg == ST_ADVANCE) ? cur_reg : work_reg;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    case (req_item.req_type)
                        REQ_BEGIN:   state_next = ST_CLOSE;
                        REQ_CONSUME: state_next = ST_ADVANCE;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADVANCE:
            begin
                if (pass_end)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (pass_end && !changed_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            data_valid_reg   <= 1'b0;
            changed_reg      <= 1'b0;
            cur_reg          <= '0;
            rsp_valid_reg    <= 1'b0;
            edges_in_use_reg <= '0;
            start_index_reg  <= '0;
            accept_index_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            data_valid_reg <= rd_en;

            // Walk index and change flag; both restart at every pass.
            if (req_accept || pass_end)
            begin
                idx_reg     <= '0;
                changed_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (data_valid_reg && (state_reg == ST_CLOSE) && unit_changed)
                begin
                    changed_reg <= 1'b1;
                end
            end

            // Result hand-off.
            if ((state_reg == ST_DONE) && rsp_free)
            begin
                cur_reg       <= work_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // Configuration writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EDGES_IN_USE: edges_in_use_reg <= cfg_data;
                    CFG_START_INDEX:  start_index_reg  <= cfg_data[SID_W-1:0];
                    CFG_ACCEPT_INDEX: accept_index_reg <= cfg_data[SID_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            char_reg <= req_item.text_byte;
            case (req_item.req_type)
                REQ_BEGIN:   work_reg <= start_dec[NS-1:0];
                REQ_CONSUME: work_reg <= '0;
                default:     work_reg <= cur_reg;
            endcase
        end
        else if (pass_end && (state_reg == ST_ADVANCE))
        begin
            work_reg <= work_reg;
        end
        else if (data_valid_reg)
        begin
            work_reg <= unit_set;
        end

        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_item_reg.matched    <= work_ext[accept_index_reg];
            rsp_item_reg.active_set <= work_ext;
        end
    end

`ifndef SYNTH
    // Table data is only in flight during a walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        data_valid_reg |-> (state_reg == ST_ADVANCE || state_reg == ST_CLOSE))
        else $error("edge data valid outside a walk");

    // The walk index never runs past the live edge count.
    assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> (idx_reg <= n_live))
        else $error("walk index beyond live edges");

    // A loaded result carries the new active set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && rsp_free) |=>
            (rsp_valid_reg && rsp_item_reg.active_set == cur_ext))
        else $error("result does not match the active set");

    // No request is taken while an item is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> !$past(req_accept))
        else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire

// ===== test/nfa_bitset_matcher_test.sv =====
// ----------------------------------------------------------------------------
// nfa_bitset_matcher_test
// Self-checking bench for the bitset NFA matcher. An in-bench model tracks
// the edge table, the registers and the active set, predicts each result and
// compares it field by field. A directed part covers empty tables, the
// extreme states, slots and bytes and every request and edge kind. Random
// phases then load small edge tables, with two table-sized phases, and run
// begin and consume strings mixed with rewrites and unused requests. Both
// channels idle and stall at random, and one phase holds results back long
// enough to fill the block.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_bitset_matcher_test;
    import nbm_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int TABLE_DEPTH    = 128;
    localparam int ITEM_GOAL      = 700;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int REPORT_LIMIT   = 10;

    // Tracks the matcher state and holds the results still owed by the block.
    class match_scoreboard;
        nbm_edge_t   arc_mem [TABLE_DEPTH];
        logic [63:0] live_set;
        logic [7:0]  used_edges;
        logic [5:0]  start_id;
        logic [5:0]  accept_id;
        nbm_out_t    expected_sets [$];
        int          failures;
        int          shown;

        function new();
            foreach (arc_mem[i])
                arc_mem[i] = '0;
            live_set   = '0;
            used_edges = '0;
            start_id   = '0;
            accept_id  = '0;
            failures   = 0;
            shown      = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_EDGES_IN_USE: used_edges = data;
                CFG_START_INDEX:  start_id   = data[5:0];
                CFG_ACCEPT_INDEX: accept_id  = data[5:0];
                default: ;
            endcase
        endfunction

        // Counts above the table depth saturate.
        function int live_edges();
            return (used_edges > TABLE_DEPTH) ? TABLE_DEPTH : int'(used_edges);
        endfunction

        // Repeats epsilon walks over the live table until the set stops growing.
        function logic [63:0] close_epsilon(logic [63:0] set_in);
            logic [63:0] grown;
            logic [63:0] prior;
            int          live;
            live  = live_edges();
            grown = set_in;
            do
            begin
                prior = grown;
                for (int i = 0; i < live; i++)
                    if (arc_mem[i].kind == KIND_EPSILON && grown[arc_mem[i].src])
                        grown[arc_mem[i].dst] = 1'b1;
            end
            while (grown != prior);
            return grown;
        endfunction

        // One step over literal and wildcard edges leaving active states.
        function logic [63:0] follow_text(logic [63:0] set_in, logic [7:0] ch);
            logic [63:0] reached;
            int          live;
            live    = live_edges();
            reached = '0;
            for (int i = 0; i < live; i++)
                if ((arc_mem[i].kind == KIND_WILDCARD ||
                     (arc_mem[i].kind == KIND_LITERAL && arc_mem[i].code == ch)) &&
                    set_in[arc_mem[i].src])
                    reached[arc_mem[i].dst] = 1'b1;
            return reached;
        endfunction

        function void note_request(nbm_in_t req);
            nbm_out_t due;
            case (req.req_type)
                REQ_WRITE:
                begin
                    arc_mem[req.edge_slot].src  = req.edge_source;
                    arc_mem[req.edge_slot].dst  = req.edge_target;
                    arc_mem[req.edge_slot].kind = req.edge_kind;
                    arc_mem[req.edge_slot].code = req.edge_byte;
                end
                REQ_BEGIN:
                begin
                    live_set = '0;
                    live_set[start_id] = 1'b1;
                    live_set = close_epsilon(live_set);
                end
                REQ_CONSUME:
                    live_set = close_epsilon(follow_text(live_set, req.text_byte));
                default: ;
            endcase
            due.matched    = live_set[accept_id];
            due.active_set = live_set;
            expected_sets.push_back(due);
        endfunction

        function void check_result(nbm_out_t got);
            nbm_out_t due;
            if (expected_sets.size() == 0)
            begin
                failures++;
                if (shown < REPORT_LIMIT)
                    $display("unexpected result: matched %0d set %h",
                             got.matched, got.active_set);
                shown++;
                return;
            end
            due = expected_sets.pop_front();
            if (got.matched !== due.matched || got.active_set !== due.active_set)
            begin
                failures++;
                if (shown < REPORT_LIMIT)
                    $display("result mismatch: expected matched %0d set %h, got matched %0d set %h",
                             due.matched, due.active_set, got.matched, got.active_set);
                shown++;
            end
        endfunction

        function int pending();
            return expected_sets.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    nbm_in_t   req_item;
    logic      rsp_valid;
    logic      rsp_stall;
    nbm_out_t  rsp_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    match_scoreboard book = new();

    // Shared between the sender and the receiver.
    int   hold_cycles_req = 0;
    int   burst_left = 0;
    bit   quiet = 1'b0;
    int   items_sent = 0;
    int   idle_cycles = 0;
    bit   slot_done [TABLE_DEPTH];
    int   span = 4;
    logic [7:0] alphabet [4];

    nfa_bitset_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Check every result as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            book.check_result(rsp_item);
    end

    // End the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: a stall pattern that changes now and then, plus long hold-offs.
    initial
    begin
        int mode;
        int tick;
        mode = 0;
        tick = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 80 == 0)
                mode = $urandom_range(0, 3);
            if (hold_cycles_req != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_cycles_req) @(negedge clk);
                hold_cycles_req = 0;
            end
            case (mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2: rsp_stall <= ($urandom_range(0, 9) < 7);
                default: rsp_stall <= ((tick % 7) < 3);
            endcase
        end
    end

    function automatic int filled_prefix();
        int count;
        count = 0;
        while (count < TABLE_DEPTH && slot_done[count])
            count++;
        return count;
    endfunction

    function automatic logic [7:0] pick_text();
        if ($urandom_range(0, 9) < 7)
            return alphabet[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Begin, consume or unused request; the edge fields carry noise.
    function automatic nbm_in_t text_item(logic [1:0] req, logic [7:0] ch);
        logic [63:0] noise;
        nbm_in_t     it;
        noise        = {$urandom, $urandom};
        it           = noise[$bits(nbm_in_t)-1:0];
        it.req_type  = req;
        it.text_byte = ch;
        return it;
    endfunction

    function automatic nbm_in_t edge_item(int slot, int src, int dst, logic [1:0] kind,
                                          logic [7:0] code);
        nbm_in_t it;
        it             = text_item(REQ_WRITE, 8'($urandom_range(0, 255)));
        it.edge_slot   = 7'(slot);
        it.edge_source = 6'(src);
        it.edge_target = 6'(dst);
        it.edge_kind   = kind;
        it.edge_byte   = code;
        return it;
    endfunction

    // Random edge among the first span states, mostly literals and epsilons.
    function automatic nbm_in_t random_edge(int slot);
        int         pick;
        logic [1:0] kind;
        logic [7:0] code;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            kind = KIND_LITERAL;
        else if (pick < 13)
            kind = KIND_EPSILON;
        else if (pick < 16)
            kind = KIND_WILDCARD;
        else
            kind = KIND_NONE;
        code = (kind == KIND_LITERAL) ? alphabet[$urandom_range(0, 3)]
                                      : 8'($urandom_range(0, 255));
        return edge_item(slot, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                         kind, code);
    endfunction

    // Offer one item, wait for it to be taken, then maybe leave a gap.
    task automatic issue(input nbm_in_t it);
        int gap;
        req_item  <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        book.note_request(it);
        if (it.req_type == REQ_WRITE)
            slot_done[it.edge_slot] = 1'b1;
        if (it.req_type != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 20);
            gap = quiet ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain_results();
        if (req_valid)
            req_valid <= 1'b0;
        @(negedge clk);
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stimulus.
    initial
    begin
        logic [7:0] table_size;
        logic [5:0] start_pick;
        logic [5:0] accept_pick;
        logic [1:0] high_bits;
        int         fill;
        int         pick;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_item  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (slot_done[i])
            slot_done[i] = 1'b0;
        alphabet[0] = 8'h61;
        alphabet[1] = 8'h00;
        alphabet[2] = 8'hFF;
        alphabet[3] = 8'h62;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: the start state alone, then nothing left to follow.
        issue(text_item(REQ_BEGIN, 8'h00));
        issue(text_item(REQ_CONSUME, 8'hFF));
        issue(text_item(REQ_UNUSED, 8'hFF));

        // A small machine touching the extreme states, bytes and slots.
        issue(edge_item(0, 0, 1, KIND_LITERAL, 8'h61));
        issue(edge_item(1, 1, 1, KIND_WILDCARD, 8'hFF));
        issue(edge_item(2, 1, 2, KIND_LITERAL, 8'h00));
        issue(edge_item(3, 2, 63, KIND_EPSILON, 8'h61));
        issue(edge_item(4, 0, 62, KIND_NONE, 8'h61));
        issue(edge_item(5, 63, 0, KIND_EPSILON, 8'h00));
        issue(edge_item(6, 1, 62, KIND_LITERAL, 8'hFF));
        issue(edge_item(7, 62, 5, KIND_EPSILON, 8'h00));
        issue(edge_item(127, 63, 63, KIND_WILDCARD, 8'hFF));
        drain_results();
        write_register(CFG_EDGES_IN_USE, 8'd8);
        write_register(CFG_START_INDEX, 8'd0);
        write_register(CFG_ACCEPT_INDEX, 8'd63);
        write_register(CFG_UNUSED, 8'hA5);
        issue(text_item(REQ_BEGIN, 8'h61));
        issue(text_item(REQ_CONSUME, 8'h61));
        issue(text_item(REQ_CONSUME, 8'h00));
        issue(text_item(REQ_CONSUME, 8'hFF));
        issue(text_item(REQ_CONSUME, 8'h61));

        // Start at the top state, written with the unused upper bits set.
        drain_results();
        write_register(CFG_START_INDEX, 8'hFF);
        write_register(CFG_ACCEPT_INDEX, 8'd0);
        issue(text_item(REQ_BEGIN, 8'h00));
        issue(text_item(REQ_CONSUME, 8'h61));

        // Random phases: load a table, set the registers, run strings.
        for (int p = 0; items_sent < ITEM_GOAL; p++)
        begin
            if (p == 3)
                table_size = 8'd128;
            else if (p == 7)
                table_size = 8'd255;
            else
                table_size = 8'($urandom_range(1, 24));
            if (table_size > 8'd24)
                span = $urandom_range(4, 12);
            else
                span = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(2, 10);
            foreach (alphabet[i])
                alphabet[i] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0)
                alphabet[0] = 8'h00;
            if ($urandom_range(0, 2) == 0)
                alphabet[1] = 8'hFF;

            // Every slot in the live range must hold a written edge.
            fill = (table_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size);
            for (int s = filled_prefix(); s < fill; s++)
                issue(random_edge(s));
            repeat ($urandom_range(0, (fill > 16) ? 8 : fill / 2))
                issue(random_edge($urandom_range(0, fill - 1)));

            drain_results();
            start_pick  = ($urandom_range(0, 7) == 0) ? 6'd63 : 6'($urandom_range(0, span - 1));
            accept_pick = ($urandom_range(0, 7) == 0) ? 6'd63 : 6'($urandom_range(0, span - 1));
            high_bits   = 2'($urandom_range(0, 3));
            write_register(CFG_EDGES_IN_USE, table_size);
            write_register(CFG_START_INDEX, {high_bits, start_pick});
            write_register(CFG_ACCEPT_INDEX, {2'b00, accept_pick});

            // One phase keeps results back while the sender keeps pushing.
            quiet = (p == 1) || ($urandom_range(0, 3) == 0);
            if (p == 1)
                hold_cycles_req = HOLD_CYCLES;

            repeat ((table_size > 8'd24) ? 3 : $urandom_range(4, 10))
            begin
                issue(text_item(REQ_BEGIN, pick_text()));
                repeat ($urandom_range(0, 8))
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        issue(random_edge($urandom_range(0, TABLE_DEPTH - 1)));
                    else if (pick == 1)
                        issue(text_item(REQ_UNUSED, pick_text()));
                    else
                        issue(text_item(REQ_CONSUME, pick_text()));
                end
            end
        end

        // Let any stray result show up before the verdict.
        drain_results();
        repeat (600) @(negedge clk);
        if (book.failures == 0 && book.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
